// ===== hw/rtl/jsve_pkg.sv =====
// Shared types and constants for the JSON string value extractor.
package jsve_pkg;

  // Field and register widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned KLEN_W    = 5;
  localparam int unsigned CAP_REG_W = 7;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned KEY_CHARS = 16;
  localparam int unsigned OUT_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LO   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HI   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd3;

  localparam logic [CAP_REG_W-1:0] CAPACITY_RST = 7'd64;

  // Parse phases
  localparam logic [2:0] PH_SEARCH = 3'd0;
  localparam logic [2:0] PH_COLON  = 3'd1;
  localparam logic [2:0] PH_OPENQ  = 3'd2;
  localparam logic [2:0] PH_VALUE  = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNTERM   = 3'd4;

  // Characters of interest
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;

  // One result item
  typedef struct packed {
    logic                kind;
    logic [BYTE_W-1:0]   char_val;
    logic [STATUS_W-1:0] status;
    logic                found;
    logic                last;
  } res_t;

  function automatic logic is_ws(input logic [BYTE_W-1:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
  endfunction

endpackage

// ===== hw/rtl/json_string_value_extractor.sv =====
// Streaming extractor of the string value that follows a configured quoted key.
// Results are registered, in the skid entry while the output register is busy.
// Throughput: one text byte per cycle if the skid entry is empty; the per-byte work
// is a parallel compare of the key window and a phase update ahead of the result
// register. A two-entry result buffer lets input continue while one result waits.
// Reset (rst_ni low, asynchronous) starts a fresh run and restores register defaults.
module json_string_value_extractor #(
  parameter int unsigned KEY_MAX   = 16,
  parameter int unsigned VALUE_MAX = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port
  input  logic                                 cfg_we_i,
  input  logic [jsve_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [jsve_pkg::CFG_W-1:0]           cfg_data_i,
  // Text input
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [jsve_pkg::BYTE_W-1:0]          s_axis_tdata,   // [7:0] text_byte
  input  logic                                 s_axis_tlast,   // end_of_text
  // Result output
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [7:0] value_char, [10:8] status_code, [11] key_found, [15:12] zero
  output logic [jsve_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                                 m_axis_tuser,   // item_kind
  output logic                                 m_axis_tlast    // final_flag
);

  localparam int unsigned WIN_DEPTH = KEY_MAX + 2;
  localparam int unsigned WIN_IDX_W = $clog2(WIN_DEPTH);
  localparam int unsigned FILL_W    = $clog2(WIN_DEPTH + 1);
  localparam int unsigned KLIM      = (KEY_MAX < jsve_pkg::KEY_CHARS) ? KEY_MAX
                                                                      : jsve_pkg::KEY_CHARS;
  localparam int unsigned CAP_W     = $clog2(VALUE_MAX + 1);
  localparam int unsigned CNT_W     = $clog2(VALUE_MAX);

  localparam logic [2:0] PH_SEARCH_C = jsve_pkg::PH_SEARCH;
  localparam logic [2:0] PH_COLON_C  = jsve_pkg::PH_COLON;
  localparam logic [2:0] PH_OPENQ_C  = jsve_pkg::PH_OPENQ;
  localparam logic [2:0] PH_VALUE_C  = jsve_pkg::PH_VALUE;

  // Configuration registers
  logic [2*jsve_pkg::CFG_W-1:0]       key_q;
  logic [jsve_pkg::KLEN_W-1:0]        key_len_q;
  logic [jsve_pkg::CAP_REG_W-1:0]     capacity_q;

  // Run state
  logic [WIN_DEPTH-1:0][jsve_pkg::BYTE_W-1:0] win_q, win_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [2:0]         phase_q, phase_d;
  logic               esc_q, esc_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  // Output buffer
  logic               out_valid_q, skid_valid_q;
  jsve_pkg::res_t     out_q, skid_q;

  // Step signals
  logic               in_fire, out_fire, eot;
  logic [jsve_pkg::BYTE_W-1:0] b;
  logic [jsve_pkg::KLEN_W-1:0] key_len_sat, eff_len;
  logic [CAP_W-1:0]   cap;
  logic               cap_full, win_hit;
  logic               res_valid;
  jsve_pkg::res_t     res;

  // Write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q      <= '0;
      key_len_q  <= '0;
      capacity_q <= jsve_pkg::CAPACITY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        jsve_pkg::REG_KEY_LO:   key_q[jsve_pkg::CFG_W-1:0] <= cfg_data_i;
        jsve_pkg::REG_KEY_HI:   key_q[2*jsve_pkg::CFG_W-1:jsve_pkg::CFG_W] <= cfg_data_i;
        jsve_pkg::REG_KEY_LEN:  key_len_q  <= cfg_data_i[jsve_pkg::KLEN_W-1:0];
        jsve_pkg::REG_CAPACITY: capacity_q <= cfg_data_i[jsve_pkg::CAP_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the key length and cut it at the first zero character
  always_comb begin
    key_len_sat = (key_len_q > jsve_pkg::KLEN_W'(KLIM)) ? jsve_pkg::KLEN_W'(KLIM) : key_len_q;
    eff_len     = key_len_sat;
    for (int m = KLIM - 1; m >= 0; m--) begin
      if ((jsve_pkg::KLEN_W'(m) < key_len_sat) &&
          (key_q[8*m +: 8] == jsve_pkg::CH_NUL)) begin
        eff_len = jsve_pkg::KLEN_W'(m);
      end
    end
  end

  // Saturate the capacity
  assign cap = (capacity_q > jsve_pkg::CAP_REG_W'(VALUE_MAX)) ? CAP_W'(VALUE_MAX)
                                                              : capacity_q[CAP_W-1:0];
  assign cap_full = (CAP_W'(cnt_q) + CAP_W'(1)) >= cap;

  assign b       = s_axis_tdata;
  assign eot     = s_axis_tlast || (b == jsve_pkg::CH_NUL);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // Shift the window and fill count
  always_comb begin
    win_d[0] = b;
    for (int k = 1; k < WIN_DEPTH; k++) begin
      win_d[k] = win_q[k-1];
    end
    fill_d = (fill_q < FILL_W'(WIN_DEPTH)) ? fill_q + FILL_W'(1) : fill_q;
  end

  // Compare the shifted window against the quoted key
  always_comb begin
    logic [WIN_IDX_W-1:0] idx;
    win_hit = (fill_d >= (FILL_W'(eff_len) + FILL_W'(2))) && (win_d[0] == jsve_pkg::CH_QUOTE);
    idx = WIN_IDX_W'(eff_len) + WIN_IDX_W'(1);
    if (win_d[idx] != jsve_pkg::CH_QUOTE) win_hit = 1'b0;
    for (int m = 0; m < KLIM; m++) begin
      idx = WIN_IDX_W'(eff_len) - WIN_IDX_W'(m);
      if ((jsve_pkg::KLEN_W'(m) < eff_len) && (win_d[idx] != key_q[8*m +: 8])) begin
        win_hit = 1'b0;
      end
    end
  end

  // Advance the parse phase and build the result
  always_comb begin
    phase_d   = phase_q;
    esc_d     = esc_q;
    cnt_d     = cnt_q;
    res_valid = 1'b0;
    res       = '0;
    res.kind  = 1'b1;
    res.found = 1'b1;
    res.last  = 1'b1;
    if (eot) begin
      unique case (phase_q)
        PH_SEARCH_C: begin
          res_valid = 1'b1;
          res.status = jsve_pkg::ST_ABSENT;
          res.found  = 1'b0;
        end
        PH_COLON_C, PH_OPENQ_C: begin
          res_valid  = 1'b1;
          res.status = jsve_pkg::ST_MISMATCH;
        end
        PH_VALUE_C: begin
          res_valid  = 1'b1;
          res.status = (esc_q && cap_full) ? jsve_pkg::ST_OVERFLOW : jsve_pkg::ST_UNTERM;
        end
        default: ;
      endcase
      phase_d = jsve_pkg::PH_SEARCH;
      esc_d   = 1'b0;
      cnt_d   = '0;
    end else begin
      unique case (phase_q)
        PH_SEARCH_C: begin
          if (win_hit) begin
            if (cap == '0) begin
              res_valid  = 1'b1;
              res.status = jsve_pkg::ST_ABSENT;
              phase_d    = jsve_pkg::PH_DONE;
            end else begin
              phase_d = jsve_pkg::PH_COLON;
            end
          end
        end
        PH_COLON_C: begin
          if (b == jsve_pkg::CH_COLON) begin
            phase_d = jsve_pkg::PH_OPENQ;
          end else if (!jsve_pkg::is_ws(b)) begin
            res_valid  = 1'b1;
            res.status = jsve_pkg::ST_MISMATCH;
            phase_d    = jsve_pkg::PH_DONE;
          end
        end
        PH_OPENQ_C: begin
          if (b == jsve_pkg::CH_QUOTE) begin
            phase_d = jsve_pkg::PH_VALUE;
          end else if (!jsve_pkg::is_ws(b)) begin
            res_valid  = 1'b1;
            res.status = jsve_pkg::ST_MISMATCH;
            phase_d    = jsve_pkg::PH_DONE;
          end
        end
        PH_VALUE_C: begin
          res_valid = 1'b1;
          if (!esc_q && (b == jsve_pkg::CH_QUOTE)) begin
            res.status = jsve_pkg::ST_OK;
            phase_d    = jsve_pkg::PH_DONE;
          end else if (!esc_q && (b == jsve_pkg::CH_BSLASH)) begin
            res_valid = 1'b0;
            esc_d     = 1'b1;
          end else if (cap_full) begin
            esc_d      = 1'b0;
            res.status = jsve_pkg::ST_OVERFLOW;
            phase_d    = jsve_pkg::PH_DONE;
          end else begin
            // Literal value byte, possibly after a backslash
            esc_d        = 1'b0;
            cnt_d        = cnt_q + CNT_W'(1);
            res.kind     = 1'b0;
            res.char_val = b;
            res.last     = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Update run state on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      fill_q  <= '0;
      phase_q <= jsve_pkg::PH_SEARCH;
      esc_q   <= 1'b0;
      cnt_q   <= '0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      cnt_q   <= cnt_d;
      if (eot) begin
        win_q  <= '0;
        fill_q <= '0;
      end else if (phase_q == jsve_pkg::PH_SEARCH) begin
        win_q  <= win_d;
        fill_q <= fill_d;
      end
    end
  end

  // Output buffer: main register plus one skid entry
  assign s_axis_tready = !skid_valid_q;
  assign out_fire      = out_valid_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_fire) begin
      out_valid_q  <= skid_valid_q || (in_fire && res_valid);
      skid_valid_q <= 1'b0;
    end else if (in_fire && res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Hold payloads; no reset needed
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_fire) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (in_fire && res_valid) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {4'b0000, out_q.found, out_q.status, out_q.char_val};

  // The skid entry is only ever filled behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a result while the output register is empty");

  // End of text always starts a fresh run
  a_eot_clears_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && eot) |=> (phase_q == jsve_pkg::PH_SEARCH) && (fill_q == '0) && !esc_q
                         && (cnt_q == '0))
    else $error("run state not cleared after end of text");

  // Value bytes are never final and always carry the key-found flag
  a_value_item_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.kind) |-> (!out_q.last && out_q.found
                                      && (out_q.status == jsve_pkg::ST_OK)))
    else $error("malformed value byte result");

endmodule

// ===== tb/json_string_value_extractor_checker.sv =====
`timescale 1ns / 1ps
// Checker for the JSON string value extractor: follows both channels, predicts and compares.
module json_string_value_extractor_checker
  import jsve_pkg::*;
#(
  parameter int unsigned KEY_MAX   = 16,
  parameter int unsigned VALUE_MAX = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] text_byte
  input  logic                  s_axis_tlast,   // end_of_text
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] value_char, [10:8] status_code, [11] key_found, [15:12] zero
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  m_axis_tuser,   // item_kind
  input  logic                  m_axis_tlast,   // final_flag
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    values_seen_o,
  output int                    statuses_seen_o,
  output int                    runs_seen_o
);

  localparam int unsigned WIN_DEPTH = KEY_MAX + 2;

  // Register copies
  logic [CFG_W-1:0]     key_lo_q  = '0;
  logic [CFG_W-1:0]     key_hi_q  = '0;
  logic [KLEN_W-1:0]    key_len_q = '0;
  logic [CAP_REG_W-1:0] cap_q     = CAPACITY_RST;

  // Parser state of the current text run
  logic [BYTE_W-1:0] window_q [WIN_DEPTH];
  logic [2:0]        phase_q = PH_SEARCH;
  logic              esc_q   = 1'b0;
  int                value_cnt_q;
  int                fill_q;

  // Extractor output still owed by the block, oldest first
  res_t extract_q [$];

  function automatic logic [BYTE_W-1:0] key_char(input int j);
    if (j < 8) return key_lo_q[8*j +: 8];
    if (j < 16) return key_hi_q[8*(j-8) +: 8];
    return CH_NUL;
  endfunction

  // Key length in use: saturated, then cut at the first NUL character
  function automatic int key_span();
    int n;
    int j;
    n = key_len_q;
    if (n > KEY_MAX) n = KEY_MAX;
    if (n > KEY_CHARS) n = KEY_CHARS;
    for (j = 0; j < n; j++) begin
      if (key_char(j) == CH_NUL) return j;
    end
    return n;
  endfunction

  function automatic int value_room();
    int c;
    c = cap_q;
    return (c > VALUE_MAX) ? VALUE_MAX : c;
  endfunction

  function automatic logic blank(input logic [BYTE_W-1:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
  endfunction

  // Window holds the quoted key, newest byte at index 0
  function automatic logic quoted_key_seen();
    int plen;
    int j;
    logic [BYTE_W-1:0] want;
    plen = key_span() + 2;
    if (fill_q < plen) return 1'b0;
    for (j = 0; j < plen; j++) begin
      want = (j == 0 || j == plen - 1) ? CH_QUOTE : key_char(j - 1);
      if (window_q[plen-1-j] != want) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_run();
    int i;
    for (i = 0; i < WIN_DEPTH; i++) window_q[i] = CH_NUL;
    phase_q     = PH_SEARCH;
    esc_q       = 1'b0;
    value_cnt_q = 0;
    fill_q      = 0;
  endtask

  task automatic owe_status(input logic [STATUS_W-1:0] code, input logic found);
    extract_q.push_back('{kind: 1'b1, char_val: '0, status: code, found: found, last: 1'b1});
    phase_q = PH_DONE;
  endtask

  // Store one literal value byte, or end the run on overflow
  task automatic owe_value_byte(input logic [BYTE_W-1:0] c);
    if (value_cnt_q + 1 >= value_room()) begin
      owe_status(ST_OVERFLOW, 1'b1);
    end else begin
      value_cnt_q++;
      extract_q.push_back('{kind: 1'b0, char_val: c, status: ST_OK, found: 1'b1, last: 1'b0});
    end
  endtask

  // Advance the parser by one accepted text request
  task automatic advance_parser(input logic [BYTE_W-1:0] b, input logic eot_flag);
    int i;
    if (eot_flag || b == CH_NUL) begin
      case (phase_q)
        PH_SEARCH: owe_status(ST_ABSENT, 1'b0);
        PH_COLON, PH_OPENQ: owe_status(ST_MISMATCH, 1'b1);
        PH_VALUE: begin
          if (esc_q && value_cnt_q + 1 >= value_room()) owe_status(ST_OVERFLOW, 1'b1);
          else owe_status(ST_UNTERM, 1'b1);
        end
        default: ;
      endcase
      clear_run();
      runs_seen_o++;
    end else begin
      case (phase_q)
        PH_SEARCH: begin
          for (i = WIN_DEPTH - 1; i > 0; i--) window_q[i] = window_q[i-1];
          window_q[0] = b;
          if (fill_q < WIN_DEPTH) fill_q++;
          if (quoted_key_seen()) begin
            if (value_room() == 0) owe_status(ST_ABSENT, 1'b1);
            else phase_q = PH_COLON;
          end
        end
        PH_COLON: begin
          if (b == CH_COLON) phase_q = PH_OPENQ;
          else if (!blank(b)) owe_status(ST_MISMATCH, 1'b1);
        end
        PH_OPENQ: begin
          if (b == CH_QUOTE) phase_q = PH_VALUE;
          else if (!blank(b)) owe_status(ST_MISMATCH, 1'b1);
        end
        PH_VALUE: begin
          if (esc_q) begin
            esc_q = 1'b0;
            owe_value_byte(b);
          end else if (b == CH_QUOTE) begin
            owe_status(ST_OK, 1'b1);
          end else if (b == CH_BSLASH) begin
            esc_q = 1'b1;
          end else begin
            owe_value_byte(b);
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic flag_field(input string field, input int unsigned want, input int unsigned got);
    if (want != got) begin
      fail_count_o++;
      if (fail_count_o <= 50)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  // Compare one accepted result request with the oldest owed item
  task automatic compare_result();
    res_t want;
    if (extract_q.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 50)
        $display("%0t: result with nothing owed, expected none, got kind %0b data %04h last %0b",
                 $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end else begin
      want = extract_q.pop_front();
      flag_field("item_kind", want.kind, m_axis_tuser);
      flag_field("value_char", want.char_val, m_axis_tdata[7:0]);
      flag_field("status_code", want.status, m_axis_tdata[10:8]);
      flag_field("key_found", want.found, m_axis_tdata[11]);
      flag_field("final_flag", want.last, m_axis_tlast);
      flag_field("tdata padding", 0, m_axis_tdata[15:12]);
      if (want.kind) statuses_seen_o++;
      else values_seen_o++;
    end
  endtask

  // Sample both channels and the register port at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_run();
      key_lo_q  = '0;
      key_hi_q  = '0;
      key_len_q = '0;
      cap_q     = CAPACITY_RST;
      extract_q.delete();
      pending_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) compare_result();
      if (s_axis_tvalid && s_axis_tready) advance_parser(s_axis_tdata, s_axis_tlast);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_KEY_LO:   key_lo_q  = cfg_data_i;
          REG_KEY_HI:   key_hi_q  = cfg_data_i;
          REG_KEY_LEN:  key_len_q = cfg_data_i[KLEN_W-1:0];
          REG_CAPACITY: cap_q     = cfg_data_i[CAP_REG_W-1:0];
          default: ;
        endcase
      end
      pending_o = extract_q.size();
    end
  end

endmodule

// ===== tb/json_string_value_extractor_tb.sv =====
`timescale 1ns / 1ps
// Top of the JSON string value extractor testbench: clock, reset, stimulus and verdict.
module json_string_value_extractor_tb;
  import jsve_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 250000;
  localparam int unsigned RANDOM_BYTES = 600;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = REG_KEY_LO;
  logic [CFG_W-1:0]      cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [BYTE_W-1:0]     s_axis_tdata  = '0;   // [7:0] text_byte
  logic                  s_axis_tlast  = 1'b0; // end_of_text
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [7:0] value_char, [10:8] status_code, [11] key_found, [15:12] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;         // item_kind
  logic                  m_axis_tlast;         // final_flag

  int fail_count;
  int pending;
  int values_seen;
  int statuses_seen;
  int runs_seen;

  // Stimulus bookkeeping
  logic              req_taken;
  int                burst_left;
  int                text_bytes;
  int                config_loads;
  int                cycle_count;
  int                stall_tick;
  logic [1:0]        stall_mode = 2'd0;
  logic [BYTE_W-1:0] key_text [KEY_CHARS];
  int                key_chars;
  int                cap_room;

  json_string_value_extractor u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  json_string_value_extractor_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tlast    (s_axis_tlast),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .m_axis_tlast    (m_axis_tlast),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .values_seen_o   (values_seen),
    .statuses_seen_o (statuses_seen),
    .runs_seen_o     (runs_seen)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Note each accepted text request, read back at the following falling edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) req_taken <= 1'b0;
    else req_taken <= s_axis_tvalid && s_axis_tready;
  end

  // Receiver back-pressure: switch at random between four stall patterns
  always @(negedge clk_i) begin
    stall_tick++;
    if (stall_tick % 256 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      2'd0: m_axis_tready = 1'b1;
      2'd1: m_axis_tready = $urandom_range(0, 1);
      2'd2: m_axis_tready = ($urandom_range(0, 3) == 0);
      default: m_axis_tready = stall_tick[2];
    endcase
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results owed", cycle_count, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one text byte in the current burst; hold it until the request is taken
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eot_flag);
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tdata  = b;
    s_axis_tlast  = eot_flag;
    s_axis_tvalid = 1'b1;
    do @(negedge clk_i); while (!req_taken);
    text_bytes++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // End the run by tlast, by a NUL byte, or by both
  task automatic finish_text(input int how);
    case (how)
      0: send_byte($urandom_range(0, 255), 1'b1);
      1: send_byte(CH_NUL, 1'b0);
      default: send_byte(CH_NUL, 1'b1);
    endcase
  endtask

  // Drop valid and let every owed result drain
  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  // Write all four registers; unused upper bits of the short ones carry noise
  task automatic load_config(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                             input logic [KLEN_W-1:0] len, input logic [CAP_REG_W-1:0] cap);
    logic [CFG_W-1:0] noise_bits;
    int j;
    wait_idle();
    write_reg(REG_KEY_LO, lo);
    write_reg(REG_KEY_HI, hi);
    noise_bits = {$urandom, $urandom};
    noise_bits[KLEN_W-1:0] = len;
    write_reg(REG_KEY_LEN, noise_bits);
    noise_bits = {$urandom, $urandom};
    noise_bits[CAP_REG_W-1:0] = cap;
    write_reg(REG_CAPACITY, noise_bits);
    config_loads++;
    for (j = 0; j < KEY_CHARS; j++) key_text[j] = (j < 8) ? lo[8*j +: 8] : hi[8*(j-8) +: 8];
    key_chars = (len > KEY_CHARS) ? KEY_CHARS : len;
    for (j = key_chars - 1; j >= 0; j--) begin
      if (key_text[j] == CH_NUL) key_chars = j;
    end
    cap_room = (cap > 64) ? 64 : cap;
  endtask

  // Step through the register extremes and some random settings
  task automatic pick_config(input int phase);
    logic [CFG_W-1:0]     lo;
    logic [CFG_W-1:0]     hi;
    logic [KLEN_W-1:0]    len;
    logic [CAP_REG_W-1:0] cap;
    int j;
    int hole;
    for (j = 0; j < 8; j++) begin
      lo[8*j +: 8] = $urandom_range(8'h23, 8'h7E);
      hi[8*j +: 8] = $urandom_range(8'h23, 8'h7E);
    end
    case (phase % 6)
      0: begin
        len = 5'd16;
        cap = 7'd64;
      end
      1: begin
        len = 5'd0;
        cap = $urandom_range(3, 10);
      end
      2: begin
        lo  = {$urandom, $urandom};
        hi  = {$urandom, $urandom};
        len = 5'd31;
        cap = 7'd127;
      end
      3: begin
        len  = $urandom_range(2, 16);
        hole = $urandom_range(0, len - 1);
        if (hole < 8) lo[8*hole +: 8] = CH_NUL;
        else hi[8*(hole-8) +: 8] = CH_NUL;
        cap = $urandom_range(1, 2);
      end
      4: begin
        len = $urandom_range(1, 8);
        cap = 7'd0;
      end
      default: begin
        len = $urandom_range(1, 16);
        cap = $urandom_range(0, 1) ? $urandom_range(2, 12) : $urandom_range(13, 64);
      end
    endcase
    load_config(lo, hi, len, cap);
  endtask

  function automatic logic [BYTE_W-1:0] pick_blank();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  // One text run: mostly key, colon and quoted value with random content;
  // the rest is noise, broken separators or cut-off text
  task automatic make_run();
    logic [BYTE_W-1:0] text_q [$];
    logic [BYTE_W-1:0] c;
    int style;
    int n;
    int i;
    style = $urandom_range(0, 9);
    if (style == 9) begin
      n = $urandom_range(1, 12);
      repeat (n) text_q.push_back($urandom_range(0, 255));
    end else begin
      repeat ($urandom_range(0, 3)) text_q.push_back($urandom_range(8'h20, 8'h7E));
      text_q.push_back(CH_QUOTE);
      for (i = 0; i < key_chars; i++) text_q.push_back(key_text[i]);
      text_q.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 2)) text_q.push_back(pick_blank());
      text_q.push_back((style == 8) ? $urandom_range(1, 255) : CH_COLON);
      repeat ($urandom_range(0, 2)) text_q.push_back(pick_blank());
      text_q.push_back((style == 7) ? $urandom_range(1, 255) : CH_QUOTE);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, cap_room + 2) : $urandom_range(0, 6);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 7) == 0) begin
          text_q.push_back(CH_BSLASH);
          text_q.push_back($urandom_range(1, 255));
        end else begin
          do c = $urandom_range(1, 255); while (c == CH_QUOTE || c == CH_BSLASH);
          text_q.push_back(c);
        end
      end
      if ($urandom_range(0, 5) != 0) text_q.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 3)) text_q.push_back($urandom_range(8'h20, 8'h7E));
      // cut the run short anywhere
      if (style == 6) text_q = text_q[0:$urandom_range(0, text_q.size() - 1)];
    end
    foreach (text_q[i]) send_byte(text_q[i], 1'b0);
    finish_text($urandom_range(0, 2));
  endtask

  initial begin : stimulus
    int phase;
    int rand_from;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset defaults: empty key, full capacity
    send_text("\"\":\"x\"");
    finish_text(0);

    // Key "k": escapes, top byte value, trailing bytes after the status
    load_config(64'h6B, 64'h0, 5'd1, 7'd64);
    send_text("\"k\" :\t\"a\\\"");
    send_byte(8'hFF, 1'b0);
    send_text("\"zz");
    finish_text(1);
    // no key, bad separator, text ending before the value and inside it
    send_text("ab");
    finish_text(2);
    send_text("\"k\"\nx");
    finish_text(0);
    send_text("\"k\":");
    finish_text(0);
    send_text("\"k\": \r\"b\\");
    finish_text(0);

    // Zero capacity, then overflow on a byte and on a pending backslash
    load_config(64'h6B, 64'h0, 5'd1, 7'd0);
    send_text("\"k\":\"a\"");
    finish_text(0);
    load_config(64'h6B, 64'h0, 5'd1, 7'd2);
    send_text("\"k\":\"ab\"");
    finish_text(1);
    send_text("\"k\":\"a\\");
    finish_text(0);
    load_config(64'h6B, 64'h0, 5'd1, 7'd1);
    send_text("\"k\":\"a");
    finish_text(2);

    // Random runs over a sequence of register settings
    phase = 0;
    rand_from = text_bytes;
    while (text_bytes - rand_from < RANDOM_BYTES) begin
      pick_config(phase);
      repeat (4) make_run();
      phase++;
    end

    wait_idle();
    repeat (16) @(negedge clk_i);
    $display("Drove %0d text bytes in %0d runs under %0d register settings",
             text_bytes, runs_seen, config_loads);
    $display("Compared %0d value bytes and %0d status items, %0d mismatches",
             values_seen, statuses_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/jsve_pkg.sv
hw/rtl/json_string_value_extractor.sv
tb/json_string_value_extractor_checker.sv
tb/json_string_value_extractor_tb.sv
